FILE: sv/neighbor_link_stats_table_assert.svh
// Assertion macros for the neighbor link statistics table
`ifndef NEIGHBOR_LINK_STATS_TABLE_ASSERT_SVH
`define NEIGHBOR_LINK_STATS_TABLE_ASSERT_SVH

// antecedent implies consequent in the next cycle
`define NLST_NEXT(lbl, clk_s, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// condition holds at every edge out of reset
`define NLST_ALWAYS(lbl, clk_s, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (cond)) else $error(msg);

`endif

FILE: sv/nlst_pkg.sv
// Package: types and constants of the neighbor link statistics table
package nlst_pkg;
	localparam int TableEntries = 64;
	localparam int SlotW = $clog2(TableEntries);
	localparam int CntW = $clog2(TableEntries + 1);
	localparam int PeriodShift = 3; // sequence numbers per period = 8
	localparam int QDepth = 2;

	localparam logic OP_BEACON = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [2:0] ST_UPDATED = 3'd0;
	localparam logic [2:0] ST_FLUSHED = 3'd1;
	localparam logic [2:0] ST_DROPPED = 3'd2;
	localparam logic [2:0] ST_EVICTED = 3'd3;
	localparam logic [2:0] ST_NONE = 3'd4;

	typedef struct packed {
		logic op;
		logic [15:0] src_address;
		logic [15:0] seq_number;
		logic signed [7:0] rssi;
		logic signed [7:0] lqi;
		logic [31:0] now_seconds;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [15:0] stat_address;
		logic [15:0] stat_received;
		logic [15:0] stat_duplicates;
		logic signed [15:0] stat_rssi_sum;
		logic signed [15:0] stat_lqi_sum;
		logic [15:0] stat_last_seq;
		logic stat_removed;
	} out_item_t;

	function automatic logic signed [15:0] sat_add(logic signed [15:0] a, logic signed [7:0] b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		if (s > 17'sd32767) return 16'sh7fff;
		if (s < -17'sd32768) return 16'sh8000;
		return s[15:0];
	endfunction

	function automatic logic [15:0] inc_sat(logic [15:0] v);
		return (v == 16'hffff) ? v : v + 16'd1;
	endfunction
endpackage

FILE: sv/nlst_front.sv
// Front: accepts items and holds them in a short queue for the back end
module nlst_front (
	input logic clk,
	input logic arst_n,
	input logic start,
	input nlst_pkg::in_item_t in_item,
	input logic pop,
	output logic busy,
	output logic q_valid,
	output nlst_pkg::in_item_t q_item
);
	localparam int PW = $clog2(nlst_pkg::QDepth);
	nlst_pkg::in_item_t mem_q [nlst_pkg::QDepth];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0] cnt_q;
	logic push;

	// one item in flight at a time: busy until its result is out
	logic hold_q;
	assign busy = hold_q;
	assign push = start && !busy;
	assign q_valid = cnt_q != '0;
	assign q_item = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
			hold_q <= 1'b0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
			if (push) hold_q <= 1'b1;
			else if (pop) hold_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_item;
	end
endmodule

FILE: sv/nlst_back.sv
// Back: sequential table scan, update, flush and eviction
module nlst_back (
	input logic clk,
	input logic arst_n,
	input logic [15:0] stale_timeout,
	input logic q_valid,
	input nlst_pkg::in_item_t q_item,
	output logic pop,
	output logic res_valid,
	output nlst_pkg::out_item_t res
);
	localparam int N = nlst_pkg::TableEntries;
	localparam int SW = nlst_pkg::SlotW;
	localparam int CW = nlst_pkg::CntW;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_EVAL = 5'b00100,
		S_ACT  = 5'b01000,
		S_FIX  = 5'b10000
	} state_t;

	state_t state_q;
	nlst_pkg::in_item_t it_q;
	logic [CW-1:0] idx_q;
	logic [N-1:0] valid_q;
	logic [15:0] birth_cnt_q;

	logic [15:0] addr_m [N];
	logic seqk_m [N];
	logic [15:0] lseq_m [N];
	logic [31:0] seen_m [N];
	logic [15:0] rsum_m [N];
	logic [15:0] lsum_m [N];
	logic [31:0] cnt_m [N];
	logic [15:0] birth_m [N];

	// registered read port
	logic [15:0] r_addr_q, r_lseq_q, r_rsum_q, r_lsum_q, r_birth_q;
	logic r_seqk_q;
	logic [31:0] r_seen_q, r_cnt_q;
	logic r_vld_q;
	logic [SW-1:0] r_idx_q;
	logic rd_pend_q;

	logic hit_q, free_q, cand_q;
	logic [SW-1:0] hit_s_q, free_s_q, cand_s_q;
	logic [15:0] cand_b_q;
	logic [SW-1:0] sel_q;
	logic [SW-1:0] rd_a;

	logic last_rd;
	logic act_edge, fire;
	nlst_pkg::out_item_t act_res;

	assign last_rd = idx_q == CW'(N - 1);
	assign rd_a = (state_q == S_SCAN || state_q == S_FIX) ? idx_q[SW-1:0] : sel_q;
	// chosen slot's data sits in the read register
	assign act_edge = state_q == S_ACT && rd_pend_q && sel_q == r_idx_q;
	assign fire = (act_edge && !(it_q.op == nlst_pkg::OP_TICK && cand_q)) ||
		(state_q == S_FIX && rd_pend_q && idx_q == '0);

	always_ff @(posedge clk) begin
		r_addr_q <= addr_m[rd_a];
		r_seqk_q <= seqk_m[rd_a];
		r_lseq_q <= lseq_m[rd_a];
		r_seen_q <= seen_m[rd_a];
		r_rsum_q <= rsum_m[rd_a];
		r_lsum_q <= lsum_m[rd_a];
		r_cnt_q <= cnt_m[rd_a];
		r_birth_q <= birth_m[rd_a];
		r_idx_q <= rd_a;
	end

	// beacon update datapath, from registered entry
	logic flush, dup, newe;
	logic [15:0] b_rsum, b_lsum, b_rc, b_dc;
	always_comb begin
		newe = !hit_q;
		flush = !newe && r_seqk_q &&
			(r_lseq_q >> nlst_pkg::PeriodShift) != (it_q.seq_number >> nlst_pkg::PeriodShift);
		dup = !newe && r_seqk_q && r_lseq_q == it_q.seq_number;
		b_rsum = (newe || flush) ? '0 : r_rsum_q;
		b_lsum = (newe || flush) ? '0 : r_lsum_q;
		b_rc = (newe || flush) ? '0 : r_cnt_q[15:0];
		b_dc = (newe || flush) ? '0 : r_cnt_q[31:16];
	end

	always_comb begin
		act_res = '0;
		if (it_q.op == nlst_pkg::OP_BEACON) begin
			if (!hit_q && !free_q) begin
				act_res.status = nlst_pkg::ST_DROPPED;
			end else if (flush) begin
				act_res.status = nlst_pkg::ST_FLUSHED;
				act_res.stat_address = r_addr_q;
				act_res.stat_received = r_cnt_q[15:0];
				act_res.stat_duplicates = r_cnt_q[31:16];
				act_res.stat_rssi_sum = r_rsum_q;
				act_res.stat_lqi_sum = r_lsum_q;
				act_res.stat_last_seq = r_lseq_q;
			end else begin
				act_res.status = nlst_pkg::ST_UPDATED;
			end
		end else if (!cand_q) begin
			act_res.status = nlst_pkg::ST_NONE;
		end else begin
			act_res.status = nlst_pkg::ST_EVICTED;
			act_res.stat_address = r_addr_q;
			act_res.stat_received = r_cnt_q[15:0];
			act_res.stat_duplicates = r_cnt_q[31:16];
			act_res.stat_rssi_sum = r_rsum_q;
			act_res.stat_lqi_sum = r_lsum_q;
			act_res.stat_last_seq = r_lseq_q;
			act_res.stat_removed = 1'b1;
		end
	end

	logic [31:0] silence;
	assign silence = it_q.now_seconds - r_seen_q;

	always_ff @(posedge clk) begin
		if (act_edge && it_q.op == nlst_pkg::OP_BEACON && (hit_q || free_q)) begin
			if (newe) begin
				addr_m[sel_q] <= it_q.src_address;
				birth_m[sel_q] <= birth_cnt_q;
			end
			seqk_m[sel_q] <= 1'b1;
			lseq_m[sel_q] <= it_q.seq_number;
			seen_m[sel_q] <= it_q.now_seconds;
			rsum_m[sel_q] <= nlst_pkg::sat_add(b_rsum, it_q.rssi);
			lsum_m[sel_q] <= nlst_pkg::sat_add(b_lsum, it_q.lqi);
			cnt_m[sel_q] <= {dup ? nlst_pkg::inc_sat(b_dc) : b_dc, nlst_pkg::inc_sat(b_rc)};
		end else if (state_q == S_FIX && rd_pend_q && r_vld_q && r_birth_q > cand_b_q) begin
			birth_m[r_idx_q] <= r_birth_q - 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			birth_cnt_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			res_valid <= 1'b0;
			pop <= 1'b0;
			hit_q <= 1'b0;
			free_q <= 1'b0;
			cand_q <= 1'b0;
			sel_q <= '0;
			hit_s_q <= '0;
			free_s_q <= '0;
			cand_s_q <= '0;
			cand_b_q <= '0;
		end else begin
			res_valid <= fire;
			pop <= fire;
			case (state_q)
				S_IDLE: begin
					if (q_valid && !pop) begin
						it_q <= q_item;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						cand_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rd_pend_q <= 1'b1;
					r_vld_q <= valid_q[idx_q[SW-1:0]];
					if (rd_pend_q) begin
						if (it_q.op == nlst_pkg::OP_BEACON) begin
							if (r_vld_q && r_addr_q == it_q.src_address && !hit_q) begin
								hit_q <= 1'b1;
								hit_s_q <= r_idx_q;
							end
							if (!r_vld_q && !free_q) begin
								free_q <= 1'b1;
								free_s_q <= r_idx_q;
							end
						end else if (r_vld_q && silence > 32'(stale_timeout) &&
							(!cand_q || r_birth_q < cand_b_q)) begin
							cand_q <= 1'b1;
							cand_s_q <= r_idx_q;
							cand_b_q <= r_birth_q;
						end
					end
					if (last_rd) state_q <= S_EVAL;
					else idx_q <= idx_q + 1'b1;
				end
				S_EVAL: begin
					// finish the last entry, then read the chosen slot
					if (it_q.op == nlst_pkg::OP_BEACON) begin
						if (r_vld_q && r_addr_q == it_q.src_address && !hit_q) begin
							hit_q <= 1'b1;
							hit_s_q <= r_idx_q;
						end
						if (!r_vld_q && !free_q) begin
							free_q <= 1'b1;
							free_s_q <= r_idx_q;
						end
					end else if (r_vld_q && silence > 32'(stale_timeout) &&
						(!cand_q || r_birth_q < cand_b_q)) begin
						cand_q <= 1'b1;
						cand_s_q <= r_idx_q;
						cand_b_q <= r_birth_q;
					end
					rd_pend_q <= 1'b0;
					state_q <= S_ACT;
				end
				S_ACT: begin
					// set sel_q, then wait until the read register holds the chosen slot's data
					if (!rd_pend_q) begin
						sel_q <= hit_q ? hit_s_q :
							(it_q.op == nlst_pkg::OP_BEACON ? free_s_q : cand_s_q);
						rd_pend_q <= 1'b1;
					end else if (act_edge) begin
						res <= act_res;
						if (it_q.op == nlst_pkg::OP_TICK && cand_q) begin
							valid_q[sel_q] <= 1'b0;
							if (birth_cnt_q != '0) birth_cnt_q <= birth_cnt_q - 16'd1;
							// renumber the rest before taking the next item
							idx_q <= '0;
							rd_pend_q <= 1'b0;
							state_q <= S_FIX;
						end else begin
							if (it_q.op == nlst_pkg::OP_BEACON && free_q && !hit_q) begin
								valid_q[sel_q] <= 1'b1;
								birth_cnt_q <= birth_cnt_q + 16'd1;
							end
							state_q <= S_IDLE;
						end
					end
				end
				S_FIX: begin
					r_vld_q <= valid_q[idx_q[SW-1:0]];
					if (rd_pend_q && idx_q == '0) begin
						// wrapped past last entry
						rd_pend_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						rd_pend_q <= 1'b1;
						idx_q <= last_rd ? '0 : idx_q + 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/neighbor_link_stats_table.sv
// Top level: neighbor link statistics table
//  channel   | ports                    | handshake
//  input     | start, busy, in_item     | taken when start && !busy
//  result    | done, out_item           | one-cycle strobe, no backpressure
//  config    | stale_timeout_we/_wdata  | written when we is high
// The done strobe follows a full pass over the 64 slots through one registered read port
// and a reread of the chosen slot; after an eviction, a second pass that renumbers
// insertion order comes before the strobe. One item is in flight; busy stays high
// through the strobe cycle and falls the cycle after.
// Reset clears valid bits and the insertion counter and sets the timeout to 20.
module neighbor_link_stats_table (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input nlst_pkg::in_item_t in_item,
	output logic done,
	output nlst_pkg::out_item_t out_item,
	input logic stale_timeout_we,
	input logic [15:0] stale_timeout_wdata
);
	`include "neighbor_link_stats_table_assert.svh"

	logic [15:0] stale_timeout_q;
	logic pop, q_valid;
	nlst_pkg::in_item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) stale_timeout_q <= 16'd20;
		else if (stale_timeout_we) stale_timeout_q <= stale_timeout_wdata;
	end

	nlst_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item), .pop(pop),
		.busy(busy), .q_valid(q_valid), .q_item(q_item)
	);

	nlst_back u_back (
		.clk(clk), .arst_n(arst_n), .stale_timeout(stale_timeout_q), .q_valid(q_valid),
		.q_item(q_item), .pop(pop), .res_valid(done), .res(out_item)
	);

	`NLST_ALWAYS(a_done_pop, clk, arst_n, done == pop, "result without dequeue")
	`NLST_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised")
	`NLST_ALWAYS(a_removed, clk, arst_n,
		!done || !out_item.stat_removed || out_item.status == nlst_pkg::ST_EVICTED,
		"removed flag on non-eviction")
endmodule

FILE: tb/tb.sv
// Testbench for the neighbor link statistics table: directed table plus random beacons and ticks
`timescale 1ns / 100ps

module tb;
	localparam int NumSlots = nlst_pkg::TableEntries;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	nlst_pkg::in_item_t in_item;
	logic done;
	nlst_pkg::out_item_t out_item;
	logic stale_timeout_we;
	logic [15:0] stale_timeout_wdata;

	neighbor_link_stats_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.done(done),
		.out_item(out_item),
		.stale_timeout_we(stale_timeout_we),
		.stale_timeout_wdata(stale_timeout_wdata)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// shadow copy of the neighbor table
	logic [15:0] timeout_q;
	logic nb_valid [NumSlots];
	logic [15:0] nb_addr [NumSlots];
	logic nb_seq_known [NumSlots];
	logic [15:0] nb_seq [NumSlots];
	logic [31:0] nb_seen [NumSlots];
	logic signed [15:0] nb_rssi [NumSlots];
	logic signed [15:0] nb_lqi [NumSlots];
	logic [15:0] nb_rx [NumSlots];
	logic [15:0] nb_dup [NumSlots];
	logic [15:0] nb_order [NumSlots];
	logic [15:0] nb_count;

	nlst_pkg::out_item_t expected_records [$];
	int errors;
	int n_beacons, n_ticks, n_flush, n_evict, n_drop;

	function automatic logic signed [15:0] clamp_add(logic signed [15:0] a,
			logic signed [7:0] b);
		int s;
		s = int'(a) + int'(b);
		if (s > 32767) s = 32767;
		if (s < -32768) s = -32768;
		return 16'(s);
	endfunction

	function automatic logic [15:0] bump(logic [15:0] v);
		return (v == 16'hffff) ? v : v + 16'd1;
	endfunction

	function automatic nlst_pkg::out_item_t slot_record(int s, logic removed);
		nlst_pkg::out_item_t r;
		r = '0;
		r.stat_address = nb_addr[s];
		r.stat_received = nb_rx[s];
		r.stat_duplicates = nb_dup[s];
		r.stat_rssi_sum = nb_rssi[s];
		r.stat_lqi_sum = nb_lqi[s];
		r.stat_last_seq = nb_seq[s];
		r.stat_removed = removed;
		return r;
	endfunction

	function automatic nlst_pkg::out_item_t predict_table(nlst_pkg::in_item_t it);
		nlst_pkg::out_item_t r;
		int s;
		r = '0;
		s = -1;
		if (it.op == nlst_pkg::OP_BEACON) begin
			n_beacons++;
			for (int i = 0; i < NumSlots; i++)
				if (s < 0 && nb_valid[i] && nb_addr[i] == it.src_address) s = i;
			if (s < 0) begin
				for (int i = 0; i < NumSlots; i++)
					if (s < 0 && !nb_valid[i]) s = i;
				if (s < 0) begin
					r.status = nlst_pkg::ST_DROPPED;
					n_drop++;
					return r;
				end
				nb_valid[s] = 1'b1;
				nb_addr[s] = it.src_address;
				nb_seq_known[s] = 1'b0;
				nb_seq[s] = '0;
				nb_rssi[s] = '0;
				nb_lqi[s] = '0;
				nb_rx[s] = '0;
				nb_dup[s] = '0;
				nb_order[s] = nb_count;
				nb_count = nb_count + 16'd1;
			end
			r.status = nlst_pkg::ST_UPDATED;
			if (nb_seq_known[s] && (nb_seq[s] >> nlst_pkg::PeriodShift) !=
				(it.seq_number >> nlst_pkg::PeriodShift)) begin
				r = slot_record(s, 1'b0);
				r.status = nlst_pkg::ST_FLUSHED;
				n_flush++;
				nb_rssi[s] = '0;
				nb_lqi[s] = '0;
				nb_rx[s] = '0;
				nb_dup[s] = '0;
			end
			nb_rssi[s] = clamp_add(nb_rssi[s], it.rssi);
			nb_lqi[s] = clamp_add(nb_lqi[s], it.lqi);
			nb_seen[s] = it.now_seconds;
			if (nb_seq_known[s] && nb_seq[s] == it.seq_number) nb_dup[s] = bump(nb_dup[s]);
			nb_rx[s] = bump(nb_rx[s]);
			nb_seq[s] = it.seq_number;
			nb_seq_known[s] = 1'b1;
			return r;
		end
		n_ticks++;
		for (int i = 0; i < NumSlots; i++)
			if (nb_valid[i] && (it.now_seconds - nb_seen[i]) > {16'd0, timeout_q})
				if (s < 0 || nb_order[i] < nb_order[s]) s = i;
		if (s < 0) begin
			r.status = nlst_pkg::ST_NONE;
			return r;
		end
		r = slot_record(s, 1'b1);
		r.status = nlst_pkg::ST_EVICTED;
		n_evict++;
		nb_valid[s] = 1'b0;
		for (int i = 0; i < NumSlots; i++)
			if (nb_valid[i] && nb_order[i] > nb_order[s]) nb_order[i] = nb_order[i] - 16'd1;
		if (nb_count > 0) nb_count = nb_count - 16'd1;
		return r;
	endfunction

	// result checker
	always @(posedge clk) begin
		nlst_pkg::out_item_t e;
		if (arst_n && done) begin
			if (expected_records.size() == 0) begin
				$error("unexpected result, status %0d", out_item.status);
				errors++;
			end else begin
				e = expected_records.pop_front();
				if (out_item.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, out_item.status); errors++; end
				if (out_item.stat_address !== e.stat_address) begin
					$error("stat_address exp %h got %h", e.stat_address, out_item.stat_address);
					errors++; end
				if (out_item.stat_received !== e.stat_received) begin
					$error("stat_received exp %0d got %0d", e.stat_received,
						out_item.stat_received); errors++; end
				if (out_item.stat_duplicates !== e.stat_duplicates) begin
					$error("stat_duplicates exp %0d got %0d", e.stat_duplicates,
						out_item.stat_duplicates); errors++; end
				if (out_item.stat_rssi_sum !== e.stat_rssi_sum) begin
					$error("stat_rssi_sum exp %0d got %0d", e.stat_rssi_sum,
						out_item.stat_rssi_sum); errors++; end
				if (out_item.stat_lqi_sum !== e.stat_lqi_sum) begin
					$error("stat_lqi_sum exp %0d got %0d", e.stat_lqi_sum,
						out_item.stat_lqi_sum); errors++; end
				if (out_item.stat_last_seq !== e.stat_last_seq) begin
					$error("stat_last_seq exp %0d got %0d", e.stat_last_seq,
						out_item.stat_last_seq); errors++; end
				if (out_item.stat_removed !== e.stat_removed) begin
					$error("stat_removed exp %0d got %0d", e.stat_removed,
						out_item.stat_removed); errors++; end
			end
		end
	end

	// hands one item over; start stays high when the next item follows at once
	task automatic send_item(nlst_pkg::in_item_t it, logic check_fixed,
			nlst_pkg::out_item_t fixed);
		nlst_pkg::out_item_t p;
		start <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (busy);
		p = predict_table(it);
		expected_records.push_back(check_fixed ? fixed : p);
	endtask

	task automatic idle_gap(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_records.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_timeout(logic [15:0] v);
		drain();
		stale_timeout_we <= 1'b1;
		stale_timeout_wdata <= v;
		@(posedge clk);
		stale_timeout_we <= 1'b0;
		timeout_q = v;
	endtask

	function automatic nlst_pkg::in_item_t mk(logic op, logic [15:0] a, logic [15:0] sq,
			logic [7:0] r, logic [7:0] l, logic [31:0] t);
		nlst_pkg::in_item_t it;
		it.op = op;
		it.src_address = a;
		it.seq_number = sq;
		it.rssi = r;
		it.lqi = l;
		it.now_seconds = t;
		return it;
	endfunction

	typedef struct {
		nlst_pkg::in_item_t it;
		logic check_fixed;
		nlst_pkg::out_item_t fixed;
	} dir_row_t;

	initial begin
		errors = 0;
		start = 1'b0;
		in_item = '0;
		stale_timeout_we = 1'b0;
		stale_timeout_wdata = '0;
		timeout_q = 16'd20;
		nb_count = '0;
		for (int i = 0; i < NumSlots; i++) nb_valid[i] = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	end

	initial begin
		dir_row_t rows [$];
		nlst_pkg::out_item_t z;
		nlst_pkg::in_item_t it;
		logic [31:0] clk_s;
		int nq;
		logic [15:0] addrs [8];
		logic [15:0] seqs [8];
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		@(posedge clk);
		z = '0;
		// tick on empty table, new neighbor, extremes, duplicate, flush, wrap-around eviction
		z.status = nlst_pkg::ST_NONE;
		rows.push_back('{mk(nlst_pkg::OP_TICK, 16'h0, 16'h0, 8'h0, 8'h0, 32'hffff_ffff),
			1'b1, z});
		z.status = nlst_pkg::ST_UPDATED;
		rows.push_back('{mk(nlst_pkg::OP_BEACON, 16'hffff, 16'hffff, 8'h7f, 8'h80,
			32'hffff_fff0), 1'b1, z});
		rows.push_back('{mk(nlst_pkg::OP_BEACON, 16'hffff, 16'hffff, 8'h7f, 8'h80,
			32'hffff_fff1), 1'b1, z});
		rows.push_back('{mk(nlst_pkg::OP_BEACON, 16'h0000, 16'h0000, 8'h80, 8'h7f, 32'd5),
			1'b1, z});
		rows.push_back('{mk(nlst_pkg::OP_BEACON, 16'h0000, 16'h0007, 8'h01, 8'hff, 32'd6),
			1'b0, z});
		rows.push_back('{mk(nlst_pkg::OP_BEACON, 16'h0000, 16'h0008, 8'hff, 8'h01, 32'd7),
			1'b0, z});
		rows.push_back('{mk(nlst_pkg::OP_BEACON, 16'hffff, 16'h0000, 8'h00, 8'h00, 32'd8),
			1'b0, z});
		// timer wrapped: 0xffff entry seen at 8, 0 entry at 7; now 30 evicts earliest inserted
		rows.push_back('{mk(nlst_pkg::OP_TICK, 16'h0, 16'h0, 8'h0, 8'h0, 32'd30), 1'b0, z});
		rows.push_back('{mk(nlst_pkg::OP_TICK, 16'h0, 16'h0, 8'h0, 8'h0, 32'd30), 1'b0, z});
		z.status = nlst_pkg::ST_NONE;
		rows.push_back('{mk(nlst_pkg::OP_TICK, 16'h0, 16'h0, 8'h0, 8'h0, 32'd30), 1'b1, z});
		foreach (rows[k]) send_item(rows[k].it, rows[k].check_fixed, rows[k].fixed);

		// saturation: one neighbor, same period, many strong beacons
		for (int k = 0; k < 300; k++)
			send_item(mk(nlst_pkg::OP_BEACON, 16'h1234, 16'd3, 8'h7f, 8'h80, 32'd40),
				1'b0, z);
		send_item(mk(nlst_pkg::OP_BEACON, 16'h1234, 16'd100, 8'h80, 8'h7f, 32'd40), 1'b0, z);

		// fill table past capacity so beacons drop
		set_timeout(16'hffff);
		for (int k = 0; k < 66; k++)
			send_item(mk(nlst_pkg::OP_BEACON, 16'(16'h4000 + k), 16'(k), 8'(k), 8'(-k),
				32'd50), 1'b0, z);
		set_timeout(16'd0);
		for (int k = 0; k < 70; k++)
			send_item(mk(nlst_pkg::OP_TICK, 16'h0, 16'h0, 8'h0, 8'h0, 32'd60), 1'b0, z);

		// random part: a small pool of neighbors with advancing sequences and time
		set_timeout(16'd20);
		clk_s = $urandom;
		for (int k = 0; k < 8; k++) begin
			addrs[k] = 16'($urandom);
			seqs[k] = 16'($urandom);
		end
		for (int n = 0; n < 1500; n++) begin
			int j;
			if (n == 700) begin
				drain();
				set_timeout(16'($urandom_range(1, 60)));
			end
			if (n < 1300 && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 7));
			clk_s = clk_s + $urandom_range(0, 6);
			j = $urandom_range(0, 7);
			case ($urandom_range(0, 9))
				0, 1: it = mk(nlst_pkg::OP_TICK, 16'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), clk_s);
				2: it = mk(nlst_pkg::OP_BEACON, 16'($urandom), 16'($urandom), 8'($urandom),
					8'($urandom), $urandom);
				default: begin
					nq = $urandom_range(0, 4);
					if (nq != 0) seqs[j] = seqs[j] + 16'(nq - 1);
					it = mk(nlst_pkg::OP_BEACON, addrs[j], seqs[j], 8'($urandom),
						8'($urandom), clk_s);
				end
			endcase
			send_item(it, 1'b0, z);
		end
		drain();
		$display("covered %0d beacons, %0d ticks: %0d flushes, %0d evictions, %0d drops",
			n_beacons, n_ticks, n_flush, n_evict, n_drop);
		if (errors == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("tb: FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
+incdir+sv
sv/nlst_pkg.sv
sv/nlst_front.sv
sv/nlst_back.sv
sv/neighbor_link_stats_table.sv
tb/tb.sv
